[rtl/bba_pkg.sv]
// Shared types, codes and the level helper function of the buddy block allocator.
package bba_pkg;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_INIT  = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_BADFREE = 2'd2;

    localparam logic [12:0] FRAG_MAX       = 13'h1FFF;
    localparam logic [3:0]  HEAP_LEVEL_RST = 4'd12;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [12:0] req_size;
        logic [11:0] block_offset;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] alloc_offset;
        logic [12:0] free_blocks;
        logic [12:0] free_bytes;
        logic [12:0] internal_frag;
    } t_out_word;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_SEED,
        S_IDLE,
        S_DECODE,
        S_A_RD,
        S_A_CHK,
        S_A_TAKE,
        S_A_SPLIT,
        S_F_ANC_RD,
        S_F_ANC_CHK,
        S_F_DSC_RD,
        S_F_DSC_CHK,
        S_F_MRG_RD,
        S_F_MRG_CHK,
        S_F_MRG_CLR,
        S_F_SET,
        S_DONE
    } t_state;

    // Smallest level whose block size covers the request; size zero maps to level 0.
    function automatic logic [3:0] level_of(input logic [12:0] size);
        logic [3:0] s;
        s = 4'd13;
        for (int i = 13; i >= 0; i--) begin
            if ((14'd1 << i) >= {1'b0, size}) begin
                s = 4'(i);
            end
        end
        return s;
    endfunction

endpackage

[rtl/bba_ram.sv]
// Single-bit free map memory with one write port and one registered read port.
module bba_ram #(
    parameter int ADDR_W = 13
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic              i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic              o_rdata
);

    logic r_mem [0:(2**ADDR_W)-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[rtl/bba_ctrl.sv]
// Sequencer that clears and seeds the free map memory and searches, splits, checks and merges blocks through it.
module bba_ctrl import bba_pkg::*; #(
    parameter int HEAP_LOG2 = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_in_word         i_in,
    input  logic [3:0]       i_heap_level,
    input  logic             i_take,
    output logic             o_idle,
    output logic             o_done,
    output t_out_word        o_res,
    output logic             o_we,
    output logic [HEAP_LOG2:0] o_waddr,
    output logic             o_wdata,
    output logic [HEAP_LOG2:0] o_raddr,
    input  logic             i_rdata
);

    localparam int LVMAX = (HEAP_LOG2 > 13) ? HEAP_LOG2 : 13;
    localparam int LVW   = $clog2(LVMAX + 2);
    localparam int VW    = LVMAX + 2;
    localparam int AW    = HEAP_LOG2 + 1;
    localparam int TOPR  = (HEAP_LOG2 < int'(HEAP_LEVEL_RST)) ? HEAP_LOG2 : int'(HEAP_LEVEL_RST);
    localparam logic [LVW-1:0] TOP_MAX = LVW'(HEAP_LOG2);
    localparam logic [LVW-1:0] TOP_RST = LVW'(TOPR);

    function automatic logic [VW-1:0] pow2(input logic [LVW-1:0] l);
        return {{(VW-1){1'b0}}, 1'b1} << l;
    endfunction

    // Tree node index: level rows are contiguous, level HEAP_LOG2 at index one.
    function automatic logic [AW-1:0] node(input logic [LVW-1:0] l, input logic [VW-1:0] off);
        logic [VW-1:0] v;
        v = pow2(TOP_MAX - l) | (off >> l);
        return v[AW-1:0];
    endfunction

    t_state         r_state, n_state;
    logic [1:0]     r_cmd, n_cmd;
    logic [12:0]    r_size, n_size;
    logic [VW-1:0]  r_off, n_off;
    logic [LVW-1:0] r_lvl, n_lvl;
    logic [LVW-1:0] r_l, n_l;
    logic [VW-1:0]  r_o, n_o;
    logic [LVW-1:0] r_top, n_top;
    logic [VW-1:0]  r_count, n_count;
    logic [VW-1:0]  r_total, n_total;
    logic [12:0]    r_frag, n_frag;
    logic [1:0]     r_status, n_status;
    logic [VW-1:0]  r_aoff, n_aoff;
    logic [AW-1:0]  r_clr, n_clr;
    logic           r_init_cmd, n_init_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_top      <= TOP_RST;
            r_init_cmd <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr      <= n_clr;
            r_top      <= n_top;
            r_init_cmd <= n_init_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_size   <= n_size;
        r_off    <= n_off;
        r_lvl    <= n_lvl;
        r_l      <= n_l;
        r_o      <= n_o;
        r_count  <= n_count;
        r_total  <= n_total;
        r_frag   <= n_frag;
        r_status <= n_status;
        r_aoff   <= n_aoff;
    end

    always_comb begin
        logic [LVW-1:0] dec_lvl;
        logic [LVW-1:0] cfg_top;
        logic [LVW-1:0] split_l;
        logic [VW-1:0]  step_o;
        logic [VW-1:0]  frag_sum;
        logic [VW-1:0]  waste;
        logic [VW-1:0]  frag_w;
        logic [VW-1:0]  frag_sub;
        logic           alloc_fin;
        logic           free_commit;

        n_state    = r_state;
        n_cmd      = r_cmd;
        n_size     = r_size;
        n_off      = r_off;
        n_lvl      = r_lvl;
        n_l        = r_l;
        n_o        = r_o;
        n_top      = r_top;
        n_count    = r_count;
        n_total    = r_total;
        n_frag     = r_frag;
        n_status   = r_status;
        n_aoff     = r_aoff;
        n_clr      = r_clr;
        n_init_cmd = r_init_cmd;
        o_we       = 1'b0;
        o_waddr    = '0;
        o_wdata    = 1'b0;
        o_raddr    = '0;
        alloc_fin   = 1'b0;
        free_commit = 1'b0;

        dec_lvl  = LVW'(level_of(r_size));
        cfg_top  = (LVW'(i_heap_level) > TOP_MAX) ? TOP_MAX : LVW'(i_heap_level);
        split_l  = r_l - LVW'(1);
        step_o   = r_o + pow2(r_l);
        frag_w   = VW'(r_frag);
        frag_sum = frag_w + pow2(r_lvl) - VW'(r_size);
        waste    = pow2(r_lvl) - VW'(r_size);
        frag_sub = frag_w - waste;

        unique case (r_state)
            S_CLEAR: begin
                o_we    = 1'b1;
                o_waddr = r_clr;
                n_clr   = r_clr + AW'(1);
                if (&r_clr) begin
                    n_state = S_SEED;
                end
            end
            S_SEED: begin
                o_we     = 1'b1;
                o_waddr  = node(r_top, '0);
                o_wdata  = 1'b1;
                n_count  = VW'(1);
                n_total  = pow2(r_top);
                n_frag   = '0;
                n_status = ST_OK;
                n_aoff   = '0;
                n_state  = r_init_cmd ? S_DONE : S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    n_cmd   = i_in.cmd;
                    n_size  = i_in.req_size;
                    n_off   = VW'(i_in.block_offset);
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_status = ST_OK;
                n_aoff   = '0;
                n_lvl    = dec_lvl;
                unique case (r_cmd)
                    CMD_ALLOC: begin
                        if (dec_lvl > r_top) begin
                            n_status = ST_NOSPACE;
                            n_state  = S_DONE;
                        end else begin
                            n_l     = dec_lvl;
                            n_o     = '0;
                            n_state = S_A_RD;
                        end
                    end
                    CMD_FREE: begin
                        if (dec_lvl > r_top
                                || (r_off & (pow2(dec_lvl) - VW'(1))) != '0
                                || r_off + pow2(dec_lvl) > pow2(r_top)) begin
                            n_status = ST_BADFREE;
                            n_state  = S_DONE;
                        end else begin
                            n_l     = dec_lvl;
                            n_state = S_F_ANC_RD;
                        end
                    end
                    CMD_INIT: begin
                        n_top      = cfg_top;
                        n_clr      = '0;
                        n_init_cmd = 1'b1;
                        n_state    = S_CLEAR;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_A_RD: begin
                o_raddr = node(r_l, r_o);
                n_state = S_A_CHK;
            end
            S_A_CHK: begin
                if (i_rdata) begin
                    n_state = S_A_TAKE;
                end else if (step_o >= pow2(r_top)) begin
                    if (r_l == r_top) begin
                        n_status = ST_NOSPACE;
                        n_state  = S_DONE;
                    end else begin
                        n_l     = r_l + LVW'(1);
                        n_o     = '0;
                        n_state = S_A_RD;
                    end
                end else begin
                    n_o     = step_o;
                    n_state = S_A_RD;
                end
            end
            S_A_TAKE: begin
                o_we    = 1'b1;
                o_waddr = node(r_l, r_o);
                n_count = r_count - VW'(1);
                if (r_l > r_lvl) begin
                    n_state = S_A_SPLIT;
                end else begin
                    alloc_fin = 1'b1;
                end
            end
            S_A_SPLIT: begin
                // The upper half of each split block becomes free.
                o_we    = 1'b1;
                o_waddr = node(split_l, r_o + pow2(split_l));
                o_wdata = 1'b1;
                n_count = r_count + VW'(1);
                n_l     = split_l;
                if (split_l == r_lvl) begin
                    alloc_fin = 1'b1;
                end
            end
            S_F_ANC_RD: begin
                o_raddr = node(r_l, r_off & ~(pow2(r_l) - VW'(1)));
                n_state = S_F_ANC_CHK;
            end
            S_F_ANC_CHK: begin
                if (i_rdata) begin
                    n_status = ST_BADFREE;
                    n_state  = S_DONE;
                end else if (r_l == r_top) begin
                    if (r_lvl == '0) begin
                        free_commit = 1'b1;
                    end else begin
                        n_l     = '0;
                        n_o     = r_off;
                        n_state = S_F_DSC_RD;
                    end
                end else begin
                    n_l     = r_l + LVW'(1);
                    n_state = S_F_ANC_RD;
                end
            end
            S_F_DSC_RD: begin
                o_raddr = node(r_l, r_o);
                n_state = S_F_DSC_CHK;
            end
            S_F_DSC_CHK: begin
                if (i_rdata) begin
                    n_status = ST_BADFREE;
                    n_state  = S_DONE;
                end else if (step_o >= r_off + pow2(r_lvl)) begin
                    if (r_l + LVW'(1) == r_lvl) begin
                        free_commit = 1'b1;
                    end else begin
                        n_l     = r_l + LVW'(1);
                        n_o     = r_off;
                        n_state = S_F_DSC_RD;
                    end
                end else begin
                    n_o     = step_o;
                    n_state = S_F_DSC_RD;
                end
            end
            S_F_MRG_RD: begin
                o_raddr = node(r_l, r_o ^ pow2(r_l));
                n_state = S_F_MRG_CHK;
            end
            S_F_MRG_CHK: begin
                n_state = i_rdata ? S_F_MRG_CLR : S_F_SET;
            end
            S_F_MRG_CLR: begin
                o_we    = 1'b1;
                o_waddr = node(r_l, r_o ^ pow2(r_l));
                n_count = r_count - VW'(1);
                n_o     = r_o & ~pow2(r_l);
                n_l     = r_l + LVW'(1);
                n_state = (r_l + LVW'(1) < r_top) ? S_F_MRG_RD : S_F_SET;
            end
            S_F_SET: begin
                o_we    = 1'b1;
                o_waddr = node(r_l, r_o);
                o_wdata = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_take) begin
                    n_init_cmd = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (alloc_fin) begin
            n_total = r_total - pow2(r_lvl);
            n_frag  = (frag_sum > VW'(FRAG_MAX)) ? FRAG_MAX : frag_sum[12:0];
            n_aoff  = r_o;
            n_state = S_DONE;
        end

        if (free_commit) begin
            n_frag  = (frag_w > waste) ? frag_sub[12:0] : '0;
            n_total = r_total + pow2(r_lvl);
            n_count = r_count + VW'(1);
            n_l     = r_lvl;
            n_o     = r_off;
            n_state = (r_lvl < r_top) ? S_F_MRG_RD : S_F_SET;
        end
    end

    assign o_idle = (r_state == S_IDLE);
    assign o_done = (r_state == S_DONE);

    assign o_res.status        = r_status;
    assign o_res.alloc_offset  = r_aoff[11:0];
    assign o_res.free_blocks   = r_count[12:0];
    assign o_res.free_bytes    = r_total[12:0];
    assign o_res.internal_frag = r_frag;

endmodule

[rtl/buddy_block_allocator_top.sv]
// An allocate scans tree nodes, takes the free block that it finds and splits it down to the
// requested level; a free checks ancestors and descendants, then merges with free buddies and
// sets the resulting block; a word rejected at decode or a no-op goes straight to the result.
// Every step goes through the single free map memory, one read or one write per cycle,
// so one word is in flight at a time and the next is taken once the result is registered.
// Reset clears the free map and seeds the top block before the first word is taken;
// a reinitialize word runs the same clearing pass.
module buddy_block_allocator_top import bba_pkg::*; #(
    parameter int HEAP_LOG2 = 12
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_word   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_word  o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [3:0] i_cfg_data
);

    logic [3:0]       r_heap_lvl;
    logic             r_out_valid;
    t_out_word        r_out_data;
    logic             ctrl_idle;
    logic             ctrl_done;
    logic             take;
    t_out_word        ctrl_res;
    logic             mem_we;
    logic [HEAP_LOG2:0] mem_waddr;
    logic             mem_wdata;
    logic [HEAP_LOG2:0] mem_raddr;
    logic             mem_rdata;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = ctrl_idle;
    assign take        = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_lvl <= HEAP_LEVEL_RST;
        end else if (i_cfg_valid) begin
            r_heap_lvl <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl_done && take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl_done && take) begin
            r_out_data <= ctrl_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    bba_ctrl #(
        .HEAP_LOG2 (HEAP_LOG2)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_in_valid && ctrl_idle),
        .i_in         (i_in_data),
        .i_heap_level (r_heap_lvl),
        .i_take       (take),
        .o_idle       (ctrl_idle),
        .o_done       (ctrl_done),
        .o_res        (ctrl_res),
        .o_we         (mem_we),
        .o_waddr      (mem_waddr),
        .o_wdata      (mem_wdata),
        .o_raddr      (mem_raddr),
        .i_rdata      (mem_rdata)
    );

    bba_ram #(
        .ADDR_W (HEAP_LOG2 + 1)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

[rtl/bba_checker.sv]
// Port-level checker for the buddy block allocator and its bind to the top level.
module bba_checker import bba_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_word  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_data
);

    // A held result word keeps its value until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result word changed while stalled");

    // Only one word is worked on at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken again while a word is in work");

    // A failed request never reports an offset.
    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status == ST_OK || o_out_data.alloc_offset == 12'd0))
        else $error("offset reported on a failed request");

    // A result never appears in the cycle right after a word is taken.
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(i_in_valid && o_in_ready))
        else $error("result appeared without processing time");

endmodule

bind buddy_block_allocator_top bba_checker u_bba_checker (.*);
